[src/msbs_pkg.sv]
// Package for the multi-signature byte scanner.
// Holds the register map, the reset signatures, the verdict codes and the
// configuration bundle shared by all modules. Depends on nothing.
package msbs_pkg;

   localparam int SIG_SLOTS = 5;
   localparam int SIG_W = 64;
   localparam int LEN_FIELD_W = 4;
   localparam int LEN_REG_W = SIG_SLOTS * LEN_FIELD_W;
   localparam int BYTE_SEL_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int SIG_IDX_W = 3;
   localparam int VERDICT_W = 2;
   localparam int LENGTH_OUT_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGNATURE_0 = 3'd0,
      CSR_SIGNATURE_1 = 3'd1,
      CSR_SIGNATURE_2 = 3'd2,
      CSR_SIGNATURE_3 = 3'd3,
      CSR_SIGNATURE_4 = 3'd4,
      CSR_LENGTHS     = 3'd5
   } csr_index_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ACCEPT   = 2'd0,
      VERDICT_BLOCKED  = 2'd1,
      VERDICT_TOO_LONG = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [SIG_SLOTS-1:0][SIG_W-1:0] signature;
      logic [LEN_REG_W-1:0]            lengths;
   } cfg_type;

   localparam logic [SIG_SLOTS-1:0][SIG_W-1:0] SIG_RESET = {
      64'd1734437990,
      64'd30518463020890483,
      64'd1295,
      64'd111559148140645,
      64'd29400045130965551
   };

   localparam logic [LEN_REG_W-1:0] LEN_RESET = 20'd291431;

endpackage

[src/msbs_ifs.sv]
// Channel interfaces of the multi-signature byte scanner: request bytes,
// verdict results and register writes, each with valid and ready.
// Depends on msbs_pkg for the field widths.
interface msbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msbs_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [msbs_pkg::VERDICT_W-1:0]           verdict;
   logic [msbs_pkg::SIG_IDX_W-1:0]           signature_index;
   logic                                     has_null;
   logic [msbs_pkg::LENGTH_OUT_W-1:0]        byte_total;

   modport source (output valid, output verdict, output signature_index,
                   output has_null, output byte_total, input ready);
   modport sink (input valid, input verdict, input signature_index,
                 input has_null, input byte_total, output ready);
endinterface

interface msbs_csr_if;
   logic                               valid;
   logic                               ready;
   logic [msbs_pkg::CSR_IDX_W-1:0]     reg_index;
   logic [msbs_pkg::SIG_W-1:0]         write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

[src/msbs_csr.sv]
// Configuration registers of the byte scanner: five signatures and the
// packed length field. Depends on msbs_pkg and the msbs_csr_if interface.
module msbs_csr (
   input  logic                clock,
   input  logic                reset,
   msbs_csr_if.sink            csr_ch,
   output msbs_pkg::cfg_type   cfg
);

   logic [msbs_pkg::SIG_SLOTS-1:0][msbs_pkg::SIG_W-1:0] sig_ff, sig_in;
   logic [msbs_pkg::LEN_REG_W-1:0]                      len_ff, len_in;
   logic                                                write_en;

   assign csr_ch.ready = 1'b1;
   assign write_en = csr_ch.valid & csr_ch.ready;

   always_comb begin
      sig_in = sig_ff;
      len_in = len_ff;
      if (write_en) begin
         case (csr_ch.reg_index)
            msbs_pkg::CSR_SIGNATURE_0: sig_in[0] = csr_ch.write_data;
            msbs_pkg::CSR_SIGNATURE_1: sig_in[1] = csr_ch.write_data;
            msbs_pkg::CSR_SIGNATURE_2: sig_in[2] = csr_ch.write_data;
            msbs_pkg::CSR_SIGNATURE_3: sig_in[3] = csr_ch.write_data;
            msbs_pkg::CSR_SIGNATURE_4: sig_in[4] = csr_ch.write_data;
            msbs_pkg::CSR_LENGTHS: len_in = csr_ch.write_data[msbs_pkg::LEN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff <= msbs_pkg::SIG_RESET;
         len_ff <= msbs_pkg::LEN_RESET;
      end else begin
         sig_ff <= sig_in;
         len_ff <= len_in;
      end
   end

   assign cfg.signature = sig_ff;
   assign cfg.lengths   = len_ff;

endmodule

[src/msbs_cell.sv]
// One window position of the scanner: compares its byte against the matching
// byte of every signature and holds that byte for the next position.
// Depends on msbs_pkg for the configuration bundle.
module msbs_cell #(
   parameter int POS = 0,
   parameter int NUM_SIGNATURES = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic                      clear,
   input  logic [7:0]                byte_in,
   input  msbs_pkg::cfg_type         cfg,
   output logic [7:0]                byte_out,
   output logic [NUM_SIGNATURES-1:0] eq
);

   logic [7:0] byte_ff;

   always_comb begin
      logic [msbs_pkg::LEN_FIELD_W-1:0] len;
      logic [msbs_pkg::LEN_FIELD_W-1:0] sel;
      for (int k = 0; k < NUM_SIGNATURES; k++) begin
         len = cfg.lengths[msbs_pkg::LEN_FIELD_W*k +: msbs_pkg::LEN_FIELD_W];
         sel = len - 4'd1 - 4'(POS);
         if (4'(POS) >= len) begin
            eq[k] = 1'b1;
         end else begin
            eq[k] = (byte_in ==
                     cfg.signature[k][8*sel[msbs_pkg::BYTE_SEL_W-1:0] +: 8]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else if (shift) begin
         byte_ff <= clear ? 8'd0 : byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

[src/multi_signature_byte_scanner.sv]
// Top level of the multi-signature byte scanner: a row of window cells,
// the per-payload counters and flags, and the verdict output register.
// Depends on msbs_pkg, the channel interfaces, msbs_csr and msbs_cell.
//
// Usage: payload bytes arrive on the req channel, one request per byte,
// with last_byte set on the final byte of a payload. Only that final byte
// produces a result on the rsp channel: the verdict, the index of the
// lowest-numbered signature that hit, a flag for any zero byte and the
// payload length, saturating one above MAX_PAYLOAD. The csr channel writes
// the five signatures and the packed lengths; it is always ready and a
// write is meant to land between payloads.
// Each cell compares its window byte with all signatures in the cycle the
// byte is taken, and the row shifts by one. The result appears in the cycle
// after the final byte is accepted and sits in an output register until
// taken. Throughput is one byte per cycle, but while that register is full
// and the receiver stalls, req.ready is low; it rises when the result leaves.
// Reset restores the built-in signatures and lengths and clears the window,
// the count and all sticky flags; no result is pending afterwards.
module multi_signature_byte_scanner #(
   parameter int MAX_PAYLOAD    = 4096,
   parameter int NUM_SIGNATURES = 5,
   parameter int MAX_SIG_LEN    = 8
) (
   input  logic       clock,
   input  logic       reset,
   msbs_req_if.sink   req_ch,
   msbs_rsp_if.source rsp_ch,
   msbs_csr_if.sink   csr_ch
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
   localparam int CMP_W = (CNT_W > msbs_pkg::LEN_FIELD_W) ? CNT_W : msbs_pkg::LEN_FIELD_W;
   localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_PAYLOAD + 1);
   localparam logic [CMP_W-1:0] PAYLOAD_LIMIT = CMP_W'(MAX_PAYLOAD);

   msbs_pkg::cfg_type cfg;

   logic                                   req_fire;
   logic                                   end_of_payload;
   logic [MAX_SIG_LEN:0][7:0]              win;
   logic [MAX_SIG_LEN-1:0][NUM_SIGNATURES-1:0] cell_eq;
   logic [msbs_pkg::SIG_SLOTS-1:0]         hits;
   logic [msbs_pkg::SIG_SLOTS-1:0]         hit_now;

   logic [CNT_W-1:0]                       count_ff, count_in;
   logic [msbs_pkg::SIG_SLOTS-1:0]         hit_ff, hit_in;
   logic                                   null_ff, null_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   msbs_pkg::verdict_type                  verdict_ff, verdict_in;
   logic [msbs_pkg::SIG_IDX_W-1:0]         index_ff, index_in;
   logic                                   has_null_ff;
   logic [msbs_pkg::LENGTH_OUT_W-1:0]      length_ff;

   msbs_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   assign req_ch.ready   = ~rsp_valid_ff | rsp_ch.ready;
   assign req_fire       = req_ch.valid & req_ch.ready;
   assign end_of_payload = req_fire & req_ch.last_byte;
   assign win[0]         = req_ch.data_byte;

   for (genvar i = 0; i < MAX_SIG_LEN; i++) begin : g_cell
      msbs_cell #(.POS(i), .NUM_SIGNATURES(NUM_SIGNATURES)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (req_fire),
         .clear    (end_of_payload),
         .byte_in  (win[i]),
         .cfg      (cfg),
         .byte_out (win[i+1]),
         .eq       (cell_eq[i])
      );
   end

   assign count_in = (count_ff < COUNT_CAP) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      logic [msbs_pkg::LEN_FIELD_W-1:0] len;
      logic                             all_eq;
      hits = '0;
      for (int k = 0; k < NUM_SIGNATURES; k++) begin
         len = cfg.lengths[msbs_pkg::LEN_FIELD_W*k +: msbs_pkg::LEN_FIELD_W];
         all_eq = 1'b1;
         for (int i = 0; i < MAX_SIG_LEN; i++) begin
            all_eq = all_eq & cell_eq[i][k];
         end
         hits[k] = all_eq && (len != '0)
                   && (len <= msbs_pkg::LEN_FIELD_W'(MAX_SIG_LEN))
                   && (CMP_W'(count_in) >= CMP_W'(len));
      end
   end

   assign hit_now = hit_ff | hits;
   assign null_in = null_ff | (req_ch.data_byte == 8'd0);
   assign hit_in  = hit_now;

   always_comb begin
      index_in = '0;
      if (CMP_W'(count_in) > PAYLOAD_LIMIT) begin
         verdict_in = msbs_pkg::VERDICT_TOO_LONG;
      end else if (hit_now != '0) begin
         verdict_in = msbs_pkg::VERDICT_BLOCKED;
         for (int k = msbs_pkg::SIG_SLOTS - 1; k >= 0; k--) begin
            if (hit_now[k]) begin
               index_in = msbs_pkg::SIG_IDX_W'(k);
            end
         end
      end else begin
         verdict_in = msbs_pkg::VERDICT_ACCEPT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (end_of_payload) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hit_ff       <= '0;
         null_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (end_of_payload) begin
            count_ff <= '0;
            hit_ff   <= '0;
            null_ff  <= 1'b0;
         end else if (req_fire) begin
            count_ff <= count_in;
            hit_ff   <= hit_in;
            null_ff  <= null_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (end_of_payload) begin
         verdict_ff  <= verdict_in;
         index_ff    <= index_in;
         has_null_ff <= null_in;
         length_ff   <= msbs_pkg::LENGTH_OUT_W'(count_in);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.verdict         = verdict_ff;
   assign rsp_ch.signature_index = index_ff;
   assign rsp_ch.has_null        = has_null_ff;
   assign rsp_ch.byte_total      = length_ff;

   // A final byte always leaves a result waiting in the next cycle.
   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      end_of_payload |=> rsp_valid_ff)
      else $error("no result after the final byte of a payload");

   // Per-payload state starts afresh after every final byte.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      end_of_payload |=> (count_ff == '0) && (hit_ff == '0) && !null_ff)
      else $error("payload state not cleared after the final byte");

   // The window of earlier bytes is empty at the start of every payload.
   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      end_of_payload |=> (win[MAX_SIG_LEN:1] == '0))
      else $error("window not cleared after the final byte");

   // The signature index is only reported with a blocked verdict.
   a_index_only_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (verdict_ff != msbs_pkg::VERDICT_BLOCKED) |-> (index_ff == '0))
      else $error("signature index set without a blocked verdict");

   // The byte count never passes its saturation value.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_CAP)
      else $error("byte count above its saturation value");

endmodule
